### design/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// shared types for the line stepper: item kinds and line set-up flags
// ----------------------------------------------------------------------------
package bls_pkg;

    // kind of input item, carried on s_tuser
    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // flags worked out when a line is set up
    typedef struct packed {
        logic x_is_major;
        logic minor_down;
        logic last;
    } line_flags_t;

endpackage

### design/bls_setup.sv
// ----------------------------------------------------------------------------
// bls_setup
// line set-up: orders the endpoints, picks the major axis, first error term
// ----------------------------------------------------------------------------
module bls_setup
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] first_x,
    output logic [COORD_BITS-1:0] first_y,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS:0]   twice_major,
    output logic [COORD_BITS:0]   twice_minor,
    output logic [COORD_BITS+2:0] err_init,
    output line_flags_t           flags
);

    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic                  xmaj, swap;

    always_comb begin
        dx   = (start_x >= end_x) ? (start_x - end_x) : (end_x - start_x);
        dy   = (start_y >= end_y) ? (start_y - end_y) : (end_y - start_y);
        xmaj = (dx >= dy);
        // order so that the major coordinate rises
        swap = xmaj ? (start_x > end_x) : (start_y > end_y);
        ax   = swap ? end_x   : start_x;
        ay   = swap ? end_y   : start_y;
        bx   = swap ? start_x : end_x;
        by   = swap ? start_y : end_y;
        dmaj = xmaj ? dx : dy;
        dmin = xmaj ? dy : dx;

        first_x     = ax;
        first_y     = ay;
        major_end   = xmaj ? bx : by;
        twice_major = {dmaj, 1'b0};
        twice_minor = {dmin, 1'b0};
        err_init    = EW'({dmin, 1'b0}) - EW'(dmaj);

        flags.x_is_major = xmaj;
        flags.minor_down = xmaj ? (by < ay) : (bx < ax);
        flags.last       = (dmaj == '0);
    end

endmodule

### design/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// integer line rasteriser, one pixel item out for each item in
// ----------------------------------------------------------------------------
// s_ channel: s_tuser selects the item kind (start or advance); on a start
// s_tdata carries both endpoints and the first pixel comes back, on an
// advance the next pixel along the major axis comes back
// m_ channel: m_tdata holds the pixel, m_tuser is high when a pixel was
// emitted (low for an advance with no line running, data then zero) and
// m_tlast marks the final pixel of the line
// the result item is in the output register in the cycle after its item
// is accepted; throughput is one item per cycle while m_tready is held high,
// set by the single output register, fed combinationally by the set-up and step logic
// the output register frees s_tready while the held item is being taken,
// so a new item is accepted in the same cycle the old result leaves
// a stalled receiver holds m_tdata/m_tuser/m_tlast and drops s_tready
// reset: no line active, output empty, all line state cleared
// ----------------------------------------------------------------------------
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // operation
    input  logic                                   s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pixel_x, pixel_y from the lowest bit up, zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    // pixel_valid
    output logic                                   m_tuser,
    // last_pixel
    output logic                                   m_tlast
);

    localparam int N   = COORD_BITS;
    localparam int EW  = N + 3;                       // error term width
    localparam int MDW = ((2*COORD_BITS+7)/8)*8;

    // line state
    logic [N-1:0]  cur_x_reg, cur_y_reg, major_end_reg;
    logic [EW-1:0] err_reg;
    logic [N:0]    twice_major_reg, twice_minor_reg;
    logic          minor_down_reg, x_is_major_reg, active_reg;

    // output register
    logic          m_tvalid_reg;
    logic [N-1:0]  pix_x_reg, pix_y_reg;
    logic          pix_valid_reg, pix_last_reg;

    logic          s_accept;
    op_t           op;

    // set-up results
    logic [N-1:0]  su_x, su_y, su_major_end;
    logic [N:0]    su_twice_major, su_twice_minor;
    logic [EW-1:0] su_err;
    line_flags_t   su_flags;

    // advance results
    logic          err_pos;
    logic [N-1:0]  adv_x, adv_y;
    logic [EW-1:0] adv_err;
    logic          adv_last;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    bls_setup #(
        .COORD_BITS (N)
    ) u_setup (
        .start_x     (s_tdata[N-1:0]),
        .start_y     (s_tdata[2*N-1:N]),
        .end_x       (s_tdata[3*N-1:2*N]),
        .end_y       (s_tdata[4*N-1:3*N]),
        .first_x     (su_x),
        .first_y     (su_y),
        .major_end   (su_major_end),
        .twice_major (su_twice_major),
        .twice_minor (su_twice_minor),
        .err_init    (su_err),
        .flags       (su_flags)
    );

    // one step along the line
    always_comb begin
        err_pos = !err_reg[EW-1] && (err_reg != '0);
        adv_x   = cur_x_reg;
        adv_y   = cur_y_reg;
        if (err_pos) begin
            if (x_is_major_reg) begin
                adv_y = minor_down_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
            end else begin
                adv_x = minor_down_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            end
        end
        if (x_is_major_reg) begin
            adv_x    = cur_x_reg + 1'b1;
            adv_last = (adv_x == major_end_reg);
        end else begin
            adv_y    = cur_y_reg + 1'b1;
            adv_last = (adv_y == major_end_reg);
        end
        adv_err = err_reg + EW'(twice_minor_reg)
                - (err_pos ? EW'(twice_major_reg) : EW'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            err_reg         <= '0;
            twice_major_reg <= '0;
            twice_minor_reg <= '0;
            minor_down_reg  <= 1'b0;
            x_is_major_reg  <= 1'b0;
            active_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            // a new item refills the output register, else a taken one empties it
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                case (op)
                    OP_START: begin
                        cur_x_reg       <= su_x;
                        cur_y_reg       <= su_y;
                        major_end_reg   <= su_major_end;
                        err_reg         <= su_err;
                        twice_major_reg <= su_twice_major;
                        twice_minor_reg <= su_twice_minor;
                        minor_down_reg  <= su_flags.minor_down;
                        x_is_major_reg  <= su_flags.x_is_major;
                        active_reg      <= !su_flags.last;
                    end
                    OP_ADVANCE: begin
                        // no line running: state stays as it is
                        if (active_reg) begin
                            cur_x_reg  <= adv_x;
                            cur_y_reg  <= adv_y;
                            err_reg    <= adv_err;
                            active_reg <= !adv_last;
                        end
                    end
                    default: begin
                        active_reg <= active_reg;
                    end
                endcase
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (op == OP_START) begin
                pix_x_reg     <= su_x;
                pix_y_reg     <= su_y;
                pix_valid_reg <= 1'b1;
                pix_last_reg  <= su_flags.last;
            end else if (active_reg) begin
                pix_x_reg     <= adv_x;
                pix_y_reg     <= adv_y;
                pix_valid_reg <= 1'b1;
                pix_last_reg  <= adv_last;
            end else begin
                pix_x_reg     <= '0;
                pix_y_reg     <= '0;
                pix_valid_reg <= 1'b0;
                pix_last_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MDW'({pix_y_reg, pix_x_reg});
    assign m_tuser  = pix_valid_reg;
    assign m_tlast  = pix_last_reg;

`ifndef ASSERT_OFF
    // every accepted item leaves a result in the output register
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    // a final pixel is always a real pixel
    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && pix_last_reg) |-> pix_valid_reg)
        else $error("last flag on an empty result");

    // a running line has not yet reached its major end
    a_active_short: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> ((x_is_major_reg ? cur_x_reg : cur_y_reg) != major_end_reg))
        else $error("active line already at its end");
`endif

endmodule
